>>> sv/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

    // Field widths fixed by the stream format
    localparam int COL_W       = 6;
    localparam int ROW_W       = 10;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;

    // Default line store size in cells
    localparam int MAX_WIDTH_DEF = 32;

    // Register reset values
    localparam logic [COL_W-1:0] WIDTH_RESET  = 6'd30;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 10'd30;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;

    // Live-neighbour counts of the B3/S23 rule
    localparam logic [COUNT_W-1:0] COUNT_SURVIVE = 4'd2;
    localparam logic [COUNT_W-1:0] COUNT_BIRTH   = 4'd3;

    // Window column: bit 2 upper row, bit 1 middle row, bit 0 lower row
    typedef logic [2:0] win_col_t;

    // Which cell a result describes, relative to the latched item
    typedef enum logic [1:0] {
        EMIT_LEFT,
        EMIT_RIGHT,
        EMIT_FLUSH
    } emit_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL,
        ST_EMIT_A,
        ST_SHIFT_Z,
        ST_EMIT_B,
        ST_FL_CLR,
        ST_FL_RD,
        ST_FL_SH,
        ST_FL_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;
        logic       load_col;
        logic       shift_zero;
        logic       flush_clr;
        logic       flush_rd;
        logic       flush_shift;
        logic       flush_inc;
        logic       emit;
        emit_kind_t kind;
        logic       last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic has_left;
        logic has_right;
        logic is_final;
        logic ptr_nz;
        logic flush_end;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/lgs_ctrl.sv
`default_nettype none

module lgs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lgs_pkg::status_t status,
    output lgs_pkg::cmd_t        cmd
);

    lgs_pkg::state_t state_reg;
    lgs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one item: read, load column, emit results, then flush at frame end
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = lgs_pkg::EMIT_LEFT;
        in_ready   = 1'b0;
        unique case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = lgs_pkg::ST_COL;
                end
            end
            lgs_pkg::ST_COL:
            begin
                cmd.load_col = 1'b1;
                if (status.has_left)
                begin
                    state_next = lgs_pkg::ST_EMIT_A;
                end
                else if (status.has_right)
                begin
                    state_next = lgs_pkg::ST_SHIFT_Z;
                end
                else if (status.is_final)
                begin
                    state_next = lgs_pkg::ST_FL_CLR;
                end
                else
                begin
                    state_next = lgs_pkg::ST_IDLE;
                end
            end
            lgs_pkg::ST_EMIT_A:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = lgs_pkg::EMIT_LEFT;
                    cmd.last = !status.has_right && !status.is_final;
                    if (status.has_right)
                    begin
                        state_next = lgs_pkg::ST_SHIFT_Z;
                    end
                    else if (status.is_final)
                    begin
                        state_next = lgs_pkg::ST_FL_CLR;
                    end
                    else
                    begin
                        state_next = lgs_pkg::ST_IDLE;
                    end
                end
            end
            lgs_pkg::ST_SHIFT_Z:
            begin
                cmd.shift_zero = 1'b1;
                state_next     = lgs_pkg::ST_EMIT_B;
            end
            lgs_pkg::ST_EMIT_B:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = lgs_pkg::EMIT_RIGHT;
                    cmd.last   = !status.is_final;
                    state_next = status.is_final ? lgs_pkg::ST_FL_CLR : lgs_pkg::ST_IDLE;
                end
            end
            lgs_pkg::ST_FL_CLR:
            begin
                cmd.flush_clr = 1'b1;
                state_next    = lgs_pkg::ST_FL_RD;
            end
            lgs_pkg::ST_FL_RD:
            begin
                cmd.flush_rd = 1'b1;
                state_next   = lgs_pkg::ST_FL_SH;
            end
            lgs_pkg::ST_FL_SH:
            begin
                cmd.flush_shift = 1'b1;
                if (status.ptr_nz)
                begin
                    state_next = lgs_pkg::ST_FL_EMIT;
                end
                else
                begin
                    cmd.flush_inc = 1'b1;
                    state_next    = lgs_pkg::ST_FL_RD;
                end
            end
            lgs_pkg::ST_FL_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = lgs_pkg::EMIT_FLUSH;
                    cmd.last = status.flush_end;
                    if (status.flush_end)
                    begin
                        state_next = lgs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.flush_inc = 1'b1;
                        state_next    = lgs_pkg::ST_FL_RD;
                    end
                end
            end
            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/lgs_datapath.sv
`default_nettype none

module lgs_datapath #(
    parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            cell_in,
    input  wire lgs_pkg::cmd_t                   cmd,
    output lgs_pkg::status_t                     status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 out_alive,
    output logic [lgs_pkg::ROW_W-1:0]            out_row,
    output logic [lgs_pkg::COL_W-1:0]            out_col,
    output logic [lgs_pkg::COUNT_W-1:0]          out_count,
    output logic                                 out_last
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = lgs_pkg::COL_W;
    localparam int ROW_W  = lgs_pkg::ROW_W;
    localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_WIDTH);

    logic [COL_W-1:0]            width_reg;
    logic [ROW_W-1:0]            height_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [COL_W-1:0]            col_reg;
    logic [ROW_W-1:0]            item_row_reg;
    logic [COL_W-1:0]            item_col_reg;
    logic                        cell_reg;
    logic [1:0]                  rd_data_reg;
    logic [1:0]                  mem [MAX_WIDTH];
    lgs_pkg::win_col_t           win_reg [3];
    logic [COL_W-1:0]            ptr_reg;
    logic                        out_valid_reg;
    logic                        out_alive_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic [COL_W-1:0]            out_col_reg;
    logic [lgs_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_last_reg;

    logic [COL_W-1:0]            w_eff;
    logic [COL_W-1:0]            w_last;
    logic [ROW_W-1:0]            h_last;
    lgs_pkg::win_col_t           new_col;
    lgs_pkg::win_col_t           flush_col;
    logic [lgs_pkg::COUNT_W-1:0] count;
    logic                        alive_next;
    logic [ROW_W-1:0]            emit_row;
    logic [COL_W-1:0]            emit_col;
    logic                        out_free;

    // Clamp the grid width to what the line store holds and raise a zero width to one
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (width_reg > MAX_COL)
        begin
            w_eff = MAX_COL;
        end
        else
        begin
            w_eff = width_reg;
        end
        w_last = w_eff - COL_W'(1);
        h_last = (height_reg == '0) ? '0 : height_reg - ROW_W'(1);
    end

    // Configuration registers and raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lgs_pkg::WIDTH_RESET;
            height_reg <= lgs_pkg::HEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lgs_pkg::CFG_NUM_COLS: width_reg  <= cfg_wdata[COL_W-1:0];
                lgs_pkg::CFG_NUM_ROWS: height_reg <= cfg_wdata[ROW_W-1:0];
                default:               ;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (col_reg == w_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Latch the item and its position
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_row_reg <= row_reg;
            item_col_reg <= col_reg;
            cell_reg     <= cell_in;
        end
    end

    // Line store: each entry holds the two rows above the current one
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg <= mem[col_reg[ADDR_W-1:0]];
        end
        else if (cmd.flush_rd && (ptr_reg < w_eff))
        begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
        if (cmd.load_col)
        begin
            mem[item_col_reg[ADDR_W-1:0]] <= {new_col[1], cell_reg};
        end
    end

    // Rows above the first one are outside the grid and read as dead
    assign new_col   = (item_row_reg == '0) ? {2'b00, cell_reg} : {rd_data_reg, cell_reg};
    assign flush_col = (ptr_reg < w_eff) ? {rd_data_reg, 1'b0} : '0;

    // Slide the 3x3 window
    always_ff @(posedge clk)
    begin
        if (cmd.load_col)
        begin
            if (item_col_reg == '0)
            begin
                win_reg[0] <= '0;
                win_reg[1] <= '0;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
            end
            win_reg[2] <= new_col;
        end
        else if (cmd.shift_zero)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= '0;
        end
        else if (cmd.flush_clr)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (cmd.flush_shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= flush_col;
        end
    end

    // Flush column pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.flush_clr)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.flush_inc)
        begin
            ptr_reg <= ptr_reg + COL_W'(1);
        end
    end

    // Count live neighbours around the window center
    always_comb
    begin
        count = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1))
                begin
                    count = count + lgs_pkg::COUNT_W'(win_reg[i][j]);
                end
            end
        end
        alive_next = (count == lgs_pkg::COUNT_BIRTH) ||
                     (win_reg[1][1] && (count == lgs_pkg::COUNT_SURVIVE));
    end

    // Position of the cell being emitted
    always_comb
    begin
        unique case (cmd.kind)
            lgs_pkg::EMIT_LEFT:
            begin
                emit_row = item_row_reg - ROW_W'(1);
                emit_col = item_col_reg - COL_W'(1);
            end
            lgs_pkg::EMIT_RIGHT:
            begin
                emit_row = item_row_reg - ROW_W'(1);
                emit_col = item_col_reg;
            end
            lgs_pkg::EMIT_FLUSH:
            begin
                emit_row = item_row_reg;
                emit_col = ptr_reg - COL_W'(1);
            end
            default:
            begin
                emit_row = item_row_reg;
                emit_col = item_col_reg;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    // Output register: hold a result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_alive_reg <= alive_next;
            out_row_reg   <= emit_row;
            out_col_reg   <= emit_col;
            out_count_reg <= count;
            out_last_reg  <= cmd.last;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.has_left  = (item_row_reg != '0) && (item_col_reg != '0);
        status.has_right = (item_row_reg != '0) && (item_col_reg == w_last);
        status.is_final  = (item_row_reg == h_last) && (item_col_reg == w_last);
        status.ptr_nz    = (ptr_reg != '0);
        status.flush_end = (ptr_reg == w_eff);
        status.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_alive = out_alive_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> sv/life_generation_stencil.sv
// Channel   Direction  Payload (lowest bit first)                         End mark
// s_axis    in         tdata: cell_alive                                   -
// m_axis    out        tdata: next_alive, cell_row, cell_col, count        tlast
// cfg       in         cfg_index 0 column count, 1 row count               -
//
// An item may give no result, or one or two results; a full output register
// stalls each of them. The last cell of a frame also flushes the final row,
// one result per cell of that row.
// Reset zeroes the raster position and loads 30x30; the line store is not
// cleared, rows outside the grid are masked instead.
// A full output register holds the controller in its emit state; a config
// write restarts the frame at cell (0,0).
`default_nettype none

module life_generation_stencil #(
    parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] cell_alive, [7:1] zero
    input  wire logic [lgs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] next_alive, [10:1] cell_row, [16:11] cell_col,
    // [20:17] neighbour_count, [23:21] zero
    output logic [lgs_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_wen,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lgs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    lgs_pkg::cmd_t    cmd;
    lgs_pkg::status_t status;

    logic                         out_alive;
    logic [lgs_pkg::ROW_W-1:0]    out_row;
    logic [lgs_pkg::COL_W-1:0]    out_col;
    logic [lgs_pkg::COUNT_W-1:0]  out_count;

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cell_in   (s_axis_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_alive (out_alive),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = {3'b000, out_count, out_col, out_row, out_alive};

endmodule

`default_nettype wire

>>> sv/lgs_checker.sv
`default_nettype none

module lgs_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [lgs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic                             m_axis_tlast
);

    logic [lgs_pkg::COUNT_W-1:0] count;
    logic                        alive;

    assign count = m_axis_tdata[20:17];
    assign alive = m_axis_tdata[0];

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // At most eight neighbours
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count <= 4'd8)
        else $error("neighbour count above eight");

    // A live result needs two or three neighbours
    a_alive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && alive |-> (count == lgs_pkg::COUNT_SURVIVE) ||
                                   (count == lgs_pkg::COUNT_BIRTH))
        else $error("live cell with wrong neighbour count");

    // Three neighbours always give a live cell
    a_birth: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (count == lgs_pkg::COUNT_BIRTH) |-> alive)
        else $error("three neighbours but dead");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
